/* src/pbm_pkg.sv */
// Package for the pixel blend unit: channel widths, blend mode codes,
// register indexes and the payload and sideband structs. No dependencies.
`default_nettype none
package pbm_pkg;

  localparam int CW = 8;             // bits per channel code
  localparam int WW = 9;             // mix weight width
  localparam int TW = 2 * CW + 1;    // first-step product width
  localparam int NW = 3 * CW + 2;    // dividend / remainder width
  localparam int DW = 2 * CW + 1;    // divisor width
  localparam int NUM_CH = 4;

  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [NW-1:0] MSQ  = NW'(CMAX) * NW'(CMAX);
  localparam logic [WW-1:0] WONE = WW'(256);

  typedef enum logic [3:0] {
    MODE_MIX      = 4'd0,
    MODE_MIN      = 4'd1,
    MODE_MAX      = 4'd2,
    MODE_OVERLAY  = 4'd3,
    MODE_SCREEN   = 4'd4,
    MODE_DIVIDE   = 4'd5,
    MODE_MULTIPLY = 4'd6,
    MODE_ADD      = 4'd7,
    MODE_SUB      = 4'd8,
    MODE_DIFF     = 4'd9
  } blend_mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WEIGHT = 2'd1,
    REG_SINGLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]    mode;
    logic [WW-1:0] weight;
    logic          single;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] first_red;
    logic [CW-1:0] first_green;
    logic [CW-1:0] first_blue;
    logic [CW-1:0] first_alpha;
    logic [CW-1:0] second_red;
    logic [CW-1:0] second_green;
    logic [CW-1:0] second_blue;
    logic [CW-1:0] second_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [CW-1:0] out_red;
    logic [CW-1:0] out_green;
    logic [CW-1:0] out_blue;
    logic [CW-1:0] out_alpha;
  } pix_out_t;

  // Values carried alongside the divider
  typedef struct packed {
    logic [CW-1:0] simple;
    logic [CW:0]   sum;
    logic          zero;
  } side_t;

endpackage
`default_nettype wire

/* src/pixel_blend_modes.sv */
// Pixel blend unit, top level: config registers, lane array, stage
// valid/ready control and output register. Depends on pbm_pkg, pbm_lane.
// Pipeline: eleven register stages (two product stages, eight divider steps,
// output register) between an accepted pixel and the output.
// Throughput: one pixel per cycle; each stage holds only while the stage
// after it is full and stalled. Reset clears valid bits and config.
`default_nettype none
module pixel_blend_modes #(
  parameter int LANES = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pbm_pkg::pix_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pbm_pkg::pix_out_t        out_data_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [pbm_pkg::WW-1:0]   cfg_wdata_i
);
  import pbm_pkg::*;

  localparam int NSTG = CW + 2;   // lane stages before the output register

  // Configuration registers: the user writes them only while the pipeline is empty; not enforced here.
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_MIX;
      cfg_q.weight <= WW'(128);
      cfg_q.single <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:   cfg_q.mode   <= cfg_wdata_i[3:0];
        REG_WEIGHT: cfg_q.weight <= cfg_wdata_i;
        REG_SINGLE: cfg_q.single <= cfg_wdata_i[0];
        default:    cfg_q.mode   <= cfg_q.mode;   // drop unknown index
      endcase
    end
  end

  // Stage control: a stage advances when it is empty or its successor
  // advances, so bubbles collapse behind a stalled output.
  logic [NSTG:0] v_q, rdy;
  always_comb begin
    rdy[NSTG] = !v_q[NSTG] || out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NSTG];

  // Split the pixel pair into per-channel operands.
  logic [CW-1:0] a_ch [NUM_CH];
  logic [CW-1:0] b_ch [NUM_CH];
  logic [CW-1:0] r_ch [NUM_CH];

  assign a_ch[0] = in_data_i.first_red;
  assign a_ch[1] = in_data_i.first_green;
  assign a_ch[2] = in_data_i.first_blue;
  assign a_ch[3] = in_data_i.first_alpha;
  assign b_ch[0] = in_data_i.second_red;
  assign b_ch[1] = in_data_i.second_green;
  assign b_ch[2] = in_data_i.second_blue;
  assign b_ch[3] = in_data_i.second_alpha;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    if (g < LANES) begin : g_on
      pbm_lane u_lane (
        .clk_i (clk_i),
        .en_i  (rdy[NSTG-1:0]),
        .cfg_i (cfg_q),
        .a_i   (a_ch[g]),
        .b_i   (b_ch[g]),
        .res_o (r_ch[g])
      );
    end else begin : g_off
      assign r_ch[g] = '0;
    end
  end

  // Output register; merge lanes and blank channels 1 to 3 for gray.
  pix_out_t out_d;
  always_comb begin
    out_d.out_red   = r_ch[0];
    out_d.out_green = cfg_q.single ? '0 : r_ch[1];
    out_d.out_blue  = cfg_q.single ? '0 : r_ch[2];
    out_d.out_alpha = cfg_q.single ? '0 : r_ch[3];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG]) out_data_o <= out_d;
  end

endmodule
`default_nettype wire

/* src/pbm_div_step.sv */
// One restoring division step: one quotient bit per stage, registered.
// Depends on pbm_pkg.
`default_nettype none
module pbm_div_step #(
  parameter int SHIFT = 0
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [pbm_pkg::NW-1:0]   rem_i,
  input  logic [pbm_pkg::DW-1:0]   den_i,
  input  logic [pbm_pkg::CW-1:0]   quo_i,
  input  pbm_pkg::side_t           side_i,
  output logic [pbm_pkg::NW-1:0]   rem_o,
  output logic [pbm_pkg::DW-1:0]   den_o,
  output logic [pbm_pkg::CW-1:0]   quo_o,
  output pbm_pkg::side_t           side_o
);
  import pbm_pkg::*;

  logic [NW-1:0] trial;
  logic          fits;

  assign trial = NW'(den_i) << SHIFT;
  assign fits  = rem_i >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= fits ? rem_i - trial : rem_i;
      quo_o  <= fits ? (quo_i | (CW'(1) << SHIFT)) : quo_i;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule
`default_nettype wire

/* src/pbm_lane.sv */
// One channel lane: products, dividend setup, pipelined rounding divider
// and the final mode select. Depends on pbm_pkg and pbm_div_step.
`default_nettype none
module pbm_lane (
  input  logic                   clk_i,
  input  logic [pbm_pkg::CW+1:0] en_i,
  input  pbm_pkg::cfg_t          cfg_i,
  input  logic [pbm_pkg::CW-1:0] a_i,
  input  logic [pbm_pkg::CW-1:0] b_i,
  output logic [pbm_pkg::CW-1:0] res_o
);
  import pbm_pkg::*;

  blend_mode_e mode;
  assign mode = blend_mode_e'(cfg_i.mode);

  // first stage
  logic [WW-1:0]   wc;
  logic [CW+WW:0]  mixv;
  logic [CW-1:0]   hi, lo, simple_d;
  logic [CW:0]     sum;
  logic [TW-1:0]   prod_d;
  logic [CW-1:0]   a_q, b_q, hi_q, simple_q;
  logic [TW-1:0]   prod_q;

  assign wc   = (cfg_i.weight > WONE) ? WONE : cfg_i.weight;
  assign mixv = (CW+WW+1)'(a_i) * (CW+WW+1)'(WONE - wc)
              + (CW+WW+1)'(b_i) * (CW+WW+1)'(wc) + (CW+WW+1)'(128);
  assign hi   = (a_i > b_i) ? a_i : b_i;
  assign lo   = (a_i > b_i) ? b_i : a_i;
  assign sum  = (CW+1)'(a_i) + (CW+1)'(b_i);

  always_comb begin
    simple_d = '0;
    prod_d   = '0;
    case (mode)
      MODE_MIX:      simple_d = mixv[CW+7:8];
      MODE_MIN:      simple_d = lo;
      MODE_MAX:      simple_d = hi;
      MODE_ADD:      simple_d = sum[CW] ? CMAX : sum[CW-1:0];
      MODE_SUB:      simple_d = (a_i > b_i) ? a_i - b_i : '0;
      MODE_DIFF:     simple_d = hi - lo;
      MODE_OVERLAY:  prod_d = TW'(a_i) * TW'(CMAX)
                            + ((TW'(b_i) * TW'(CMAX - a_i)) << 1);
      MODE_SCREEN,
      MODE_MULTIPLY: prod_d = TW'(a_i) * TW'(b_i);
      MODE_DIVIDE:   prod_d = TW'(a_i) * TW'(CMAX);
      default:       simple_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q      <= a_i;
      b_q      <= b_i;
      hi_q     <= hi;
      simple_q <= simple_d;
      prod_q   <= prod_d;
    end
  end

  // second stage: rounded-division operands
  logic [NW-1:0] num_d;
  logic [DW-1:0] den_d;
  side_t         side_d;

  always_comb begin
    num_d = '0;
    den_d = DW'(1);
    case (mode)
      MODE_OVERLAY: begin
        num_d = ((NW'(a_q) * NW'(prod_q)) << 1) + MSQ;
        den_d = DW'(MSQ << 1);
      end
      MODE_SCREEN, MODE_MULTIPLY: begin
        num_d = (NW'(prod_q) << 1) + NW'(CMAX);
        den_d = DW'(CMAX) << 1;
      end
      MODE_DIVIDE: begin
        num_d = (NW'(prod_q) << 1) + NW'(hi_q);
        den_d = DW'(hi_q) << 1;
      end
      default: num_d = '0;
    endcase
    side_d.simple = simple_q;
    side_d.sum    = (CW+1)'(a_q) + (CW+1)'(b_q);
    side_d.zero   = (hi_q == '0);
  end

  logic [NW-1:0] rem_s  [CW+1];
  logic [DW-1:0] den_s  [CW+1];
  logic [CW-1:0] quo_s  [CW+1];
  side_t         side_s [CW+1];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rem_s[0]  <= num_d;
      den_s[0]  <= den_d;
      quo_s[0]  <= '0;
      side_s[0] <= side_d;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_div
    pbm_div_step #(.SHIFT(CW - 1 - k)) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i[k+2]),
      .rem_i  (rem_s[k]),
      .den_i  (den_s[k]),
      .quo_i  (quo_s[k]),
      .side_i (side_s[k]),
      .rem_o  (rem_s[k+1]),
      .den_o  (den_s[k+1]),
      .quo_o  (quo_s[k+1]),
      .side_o (side_s[k+1])
    );
  end

  // final select; the remainder and divisor of the last step are spent
  logic [CW-1:0] q;
  side_t         sd;
  assign q  = quo_s[CW];
  assign sd = side_s[CW];

  always_comb begin
    case (mode)
      MODE_SCREEN:   res_o = CW'(sd.sum - (CW+1)'(q));
      MODE_OVERLAY,
      MODE_MULTIPLY: res_o = q;
      MODE_DIVIDE:   res_o = sd.zero ? '0 : q;
      default:       res_o = sd.simple;
    endcase
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench for pixel_blend_modes: random and directed pixel pairs under every
// blend mode, checked against a behavioral predictor. Depends on pbm_pkg.
`timescale 1ns / 100ps
module testbench;
  import pbm_pkg::*;

  // Expected pixels in transfer order, and the blend settings they depend on.
  class blend_scoreboard;
    pix_out_t    pending_pixels[$];
    logic [3:0]  mode;
    logic [8:0]  weight;
    logic        single;
    int          mismatches;

    function new();
      mode = 4'(MODE_MIX);
      weight = 9'd128;
      single = 1'b0;
      mismatches = 0;
    endfunction

    function logic [7:0] div_nearest(longint unsigned num, longint unsigned den);
      return 8'((2 * num + den) / (2 * den));
    endfunction

    function logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b);
      longint unsigned ua, ub, m, w, hi, lo;
      ua = a; ub = b; m = 255;
      w = (weight > 256) ? 256 : weight;
      hi = (ua > ub) ? ua : ub;
      lo = (ua > ub) ? ub : ua;
      case (mode)
        MODE_MIX:      return 8'((ua * (256 - w) + ub * w + 128) >> 8);
        MODE_MIN:      return 8'(lo);
        MODE_MAX:      return 8'(hi);
        MODE_OVERLAY:  return div_nearest(ua * (ua * m + 2 * ub * (m - ua)), m * m);
        MODE_SCREEN:   return 8'(ua + ub - div_nearest(ua * ub, m));
        MODE_DIVIDE:   return (hi == 0) ? 8'd0 : div_nearest(ua * m, hi);
        MODE_MULTIPLY: return div_nearest(ua * ub, m);
        MODE_ADD:      return (ua + ub > m) ? 8'(m) : 8'(ua + ub);
        MODE_SUB:      return (ua > ub) ? 8'(ua - ub) : 8'd0;
        MODE_DIFF:     return 8'(hi - lo);
        default:       return 8'd0;
      endcase
    endfunction

    function void note_input(pix_in_t p);
      pix_out_t e;
      e = '0;
      e.out_red = blend_channel(p.first_red, p.second_red);
      if (!single) begin
        e.out_green = blend_channel(p.first_green, p.second_green);
        e.out_blue  = blend_channel(p.first_blue, p.second_blue);
        e.out_alpha = blend_channel(p.first_alpha, p.second_alpha);
      end
      pending_pixels.push_back(e);
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t e;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output pixel %h", got);
        return;
      end
      e = pending_pixels.pop_front();
      if (got.out_red != e.out_red || got.out_green != e.out_green ||
          got.out_blue != e.out_blue || got.out_alpha != e.out_alpha) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch mode %0d: expected %h got %h", mode, e, got);
      end
    endfunction
  endclass

  localparam int LATENCY = 11;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  pix_in_t        in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  pix_out_t       out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_idx_i = '0;
  logic [WW-1:0]  cfg_wdata_i = '0;

  blend_scoreboard blend_sb = new();
  bit stim_done = 1'b0;
  bit output_stall_on = 1'b1;
  int stall_left = 0;

  always #1 clk_i = ~clk_i;

  pixel_blend_modes DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // Mostly short gaps, a few long ones, and plenty of none at all.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Write one register; the block must be idle.
  task automatic write_reg(cfg_reg_e idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= WW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:   blend_sb.mode = 4'(value);
      REG_WEIGHT: blend_sb.weight = 9'(value);
      default:    blend_sb.single = 1'(value);
    endcase
    @(posedge clk_i);
  endtask

  // Present one pixel pair and hold it until the transfer; valid stays
  // high across back-to-back transfers and drops only for a gap.
  task automatic send_pixel(pix_in_t p, bit allow_gap);
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    blend_sb.note_input(p);
  endtask

  // Drain all pending pixels, then let the pipeline settle before a write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (blend_sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  function pix_in_t random_pixel();
    pix_in_t p;
    int r;
    p = pix_in_t'({$urandom, $urandom});
    // Bias some channels toward equal values and the ends of the range.
    r = $urandom_range(0, 9);
    if (r == 0) p.second_red = p.first_red;
    if (r == 1) p = '0;
    if (r == 2) p = '1;
    if (r == 3) begin
      p.first_green = 8'd0;
      p.second_green = 8'd0;
    end
    return p;
  endfunction

  // Receiver: random back-pressure; sample and check on each output transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) blend_sb.check_result(out_data_o);
      if (!output_stall_on) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  <= pick_gap();
      end
    end
  end

  initial begin
    pix_in_t p;
    int w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner pixels under each mode, including unused mode codes.
    for (int m = 0; m < 12; m++) begin
      write_reg(REG_MODE, (m == 10) ? 15 : (m == 11) ? 10 : m);
      send_pixel('0, 1'b0);
      send_pixel('1, 1'b0);
      send_pixel(pix_in_t'({8'hff, 8'h00, 8'h80, 8'h01, 8'h00, 8'hff, 8'h80, 8'hfe}), 1'b0);
      wait_idle();
    end
    // Weight extremes, saturation above 256, and single channel mode.
    write_reg(REG_MODE, MODE_MIX);
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_WEIGHT, (k == 0) ? 0 : (k == 1) ? 256 : (k == 2) ? 511 : 257);
      send_pixel(pix_in_t'({8'hff, 8'h10, 8'h00, 8'h7f, 8'h00, 8'hf0, 8'hff, 8'h80}), 1'b0);
      wait_idle();
    end
    write_reg(REG_SINGLE, 1);
    send_pixel('1, 1'b0);
    wait_idle();
    write_reg(REG_SINGLE, 0);

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(REG_MODE, ($urandom_range(0, 19) == 0) ? $urandom_range(10, 15)
                                                       : $urandom_range(0, 9));
      w = $urandom_range(0, 3);
      write_reg(REG_WEIGHT, (w == 0) ? 0 : (w == 1) ? 256 : $urandom_range(0, 511));
      write_reg(REG_SINGLE, $urandom_range(0, 3) == 0);
      output_stall_on = (ph % 4 != 3);
      for (int i = 0; i < 40; i++) begin
        p = random_pixel();
        send_pixel(p, ph % 5 != 0);
      end
      wait_idle();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (LATENCY * 4) @(posedge clk_i);
    if (blend_sb.pending_pixels.size() == 0 && blend_sb.mismatches == 0)
      $display("pixel_blend_modes regression: pass");
    else
      $display("pixel_blend_modes regression: fail");
    $finish;
  end

  initial begin
    #400000;
    $display("pixel_blend_modes regression: fail");
    $finish;
  end
endmodule
